// ===== rtl/gbfs_pkg.sv =====
// Shared types and constants of the grid breadth-first search block.
package gbfs_pkg;

    localparam int CFG_W      = 6;
    localparam int CFG_ADDR_W = 1;
    localparam int KIND_W     = 2;
    localparam int STEP_W     = 11;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_ROWS = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_COLS = 1'b1;
    localparam logic [CFG_W-1:0]      SIDE_RESET = 6'd32;

    typedef enum logic [KIND_W-1:0] {
        KIND_OPEN  = 2'd0,
        KIND_WALL  = 2'd1,
        KIND_START = 2'd2,
        KIND_GOAL  = 2'd3
    } cell_kind_t;

    // Neighbor order: up, right, left, down
    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_DOWN  = 2'd3
    } dir_t;

    function automatic dir_t dir_advance(input dir_t d);
        dir_t n;
        case (d)
            DIR_UP:    n = DIR_RIGHT;
            DIR_RIGHT: n = DIR_LEFT;
            DIR_LEFT:  n = DIR_DOWN;
            default:   n = DIR_UP;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/gbfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gbfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/gbfs_nbr.sv =====
// Neighbor address unit: one add/subtract and edge compare per direction.
module gbfs_nbr #(
    parameter int MAX_SIDE = 32
) (
    input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] cur_idx,
    input  logic [$clog2(MAX_SIDE)-1:0]          cur_row,
    input  logic [$clog2(MAX_SIDE)-1:0]          cur_col,
    input  gbfs_pkg::dir_t                       dir,
    input  logic [gbfs_pkg::CFG_W-1:0]           rows_use,
    input  logic [gbfs_pkg::CFG_W-1:0]           cols_use,
    output logic                                 nb_ok,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] nb_idx,
    output logic [$clog2(MAX_SIDE)-1:0]          nb_row,
    output logic [$clog2(MAX_SIDE)-1:0]          nb_col
);
    import gbfs_pkg::*;

    localparam int IDX_W = $clog2(MAX_SIDE*MAX_SIDE);
    localparam int RC_W  = $clog2(MAX_SIDE);
    localparam int CMP_W = ((RC_W > CFG_W) ? RC_W : CFG_W) + 1;

    logic             vertical;
    logic             backward;
    logic [IDX_W-1:0] delta;

    assign vertical = (dir == DIR_UP) || (dir == DIR_DOWN);
    assign backward = (dir == DIR_UP) || (dir == DIR_LEFT);
    assign delta    = vertical ? IDX_W'(cols_use) : IDX_W'(1);
    assign nb_idx   = backward ? (cur_idx - delta) : (cur_idx + delta);

    always_comb begin
        nb_row = cur_row;
        nb_col = cur_col;
        case (dir)
            DIR_UP: begin
                nb_ok  = (cur_row != '0);
                nb_row = cur_row - RC_W'(1);
            end
            DIR_RIGHT: begin
                nb_ok  = (CMP_W'(cur_col) + CMP_W'(1)) < CMP_W'(cols_use);
                nb_col = cur_col + RC_W'(1);
            end
            DIR_LEFT: begin
                nb_ok  = (cur_col != '0);
                nb_col = cur_col - RC_W'(1);
            end
            default: begin
                nb_ok  = (CMP_W'(cur_row) + CMP_W'(1)) < CMP_W'(rows_use);
                nb_row = cur_row + RC_W'(1);
            end
        endcase
    end

endmodule

// ===== rtl/grid_bfs_shortest_path.sv =====
// Top level of the grid shortest-path search: cell loader, search sequencer, result register.
//
// Usage: set grid_rows (index 0) and grid_cols (index 1) on the cfg port while idle; a value
// of 0 counts as 1 and a value above MAX_SIDE as MAX_SIDE. Then stream the grid in row-major
// order on the s_ channel, one cell code per word (tdata[1:0]: 0 open, 1 wall, 2 start,
// 3 goal); tlast marks the final cell. Cells past rows*cols are dropped.
// Loading takes one cell per cycle while s_tready is high. The word with tlast starts the
// search and s_tready stays low until it ends. The search first sweeps the grid to seed every
// start cell, then pops the frontier queue one cell at a time and checks its neighbors in
// turn, the one neighbor unit and the single read port of the grid memory serving each.
// A search ends when the queue runs dry or a goal is seen, and the result word
// (m_tdata bit 0 goal_found, bits 11:1 step_count) is then placed in the output register.
// A stalled receiver holds the result word; the next grid loads meanwhile, and the next
// search waits at its end until the held word is taken.
// Reset (aresetn low, synchronous) empties the queue, drops any pending result, sets the
// load position to zero and both sides to 32. The grid memory keeps its contents.
module grid_bfs_shortest_path #(
    parameter int MAX_SIDE = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [gbfs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [gbfs_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [gbfs_pkg::S_TDATA_W-1:0]   s_tdata,   // [1:0] cell_kind, [7:2] zero
    input  logic                             s_tlast,   // last_cell
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [gbfs_pkg::M_TDATA_W-1:0]   m_tdata    // [0] goal_found, [11:1] step_count
);
    import gbfs_pkg::*;

    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int IDX_W = $clog2(CELLS);
    localparam int LP_W  = IDX_W + 1;
    localparam int RC_W  = $clog2(MAX_SIDE);
    localparam int CMP_W = ((RC_W > CFG_W) ? RC_W : CFG_W) + 1;
    localparam int QW    = IDX_W + 2 * RC_W + STEP_W;
    localparam int PAD_W = M_TDATA_W - 1 - STEP_W;
    localparam logic [LP_W-1:0] CELL_MAX = LP_W'(CELLS);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DEQ,
        ST_POP,
        ST_NBR,
        ST_CHK,
        ST_DONE
    } state_t;

    function automatic logic [CFG_W-1:0] side_use(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return CFG_W'(1);
        end
        if (32'(v) > MAX_SIDE) begin
            return CFG_W'(MAX_SIDE);
        end
        return v;
    endfunction

    // Registers
    state_t                state_reg,    state_next;
    logic [CFG_W-1:0]      rows_reg,     rows_next;
    logic [CFG_W-1:0]      cols_reg,     cols_next;
    logic [LP_W-1:0]       load_pos_reg, load_pos_next;
    logic [LP_W-1:0]       scan_i_reg,   scan_i_next;
    logic [RC_W-1:0]       scan_row_reg, scan_row_next;
    logic [RC_W-1:0]       scan_col_reg, scan_col_next;
    logic                  pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0]      pipe_idx_reg, pipe_idx_next;
    logic [RC_W-1:0]       pipe_row_reg, pipe_row_next;
    logic [RC_W-1:0]       pipe_col_reg, pipe_col_next;
    logic [LP_W-1:0]       head_reg,     head_next;
    logic [LP_W-1:0]       tail_reg,     tail_next;
    logic [IDX_W-1:0]      cur_idx_reg,  cur_idx_next;
    logic [RC_W-1:0]       cur_row_reg,  cur_row_next;
    logic [RC_W-1:0]       cur_col_reg,  cur_col_next;
    logic [STEP_W-1:0]     cur_step_reg, cur_step_next;
    dir_t                  dir_reg,      dir_next;
    logic [IDX_W-1:0]      nb_idx_reg,   nb_idx_next;
    logic [RC_W-1:0]       nb_row_reg,   nb_row_next;
    logic [RC_W-1:0]       nb_col_reg,   nb_col_next;
    logic                  found_reg,    found_next;
    logic [STEP_W-1:0]     steps_reg,    steps_next;
    logic                  m_valid_reg,  m_valid_next;
    logic [M_TDATA_W-1:0]  m_data_reg,   m_data_next;

    // Derived sizes
    logic [CFG_W-1:0]   rows_use;
    logic [CFG_W-1:0]   cols_use;
    logic [2*CFG_W-1:0] tot_prod;
    logic [LP_W-1:0]    total;

    assign rows_use = side_use(rows_reg);
    assign cols_use = side_use(cols_reg);
    assign tot_prod = rows_use * cols_use;
    assign total    = LP_W'(tot_prod);

    // Memory ports
    logic              cell_we;
    logic [IDX_W-1:0]  cell_raddr;
    logic [KIND_W-1:0] cell_rdata;
    logic              vis_we;
    logic [IDX_W-1:0]  vis_waddr;
    logic              vis_wdata;
    logic              vis_rdata;
    logic              q_we;
    logic [QW-1:0]     q_wdata;
    logic [QW-1:0]     q_rdata;

    // Neighbor unit
    logic              nb_ok;
    logic [IDX_W-1:0]  nb_idx;
    logic [RC_W-1:0]   nb_row;
    logic [RC_W-1:0]   nb_col;

    // Queue word fields
    logic [STEP_W-1:0] q_step;
    cell_kind_t        rd_kind;
    logic              s_accept;

    assign q_step   = q_rdata[IDX_W + 2*RC_W +: STEP_W];
    assign rd_kind  = cell_kind_t'(cell_rdata);
    assign s_tready = (state_reg == ST_LOAD);
    assign s_accept = s_tvalid && s_tready;
    assign cell_we  = s_accept && (load_pos_reg < total);
    assign cell_raddr = (state_reg == ST_SCAN) ? scan_i_reg[IDX_W-1:0] : nb_idx;

    gbfs_nbr #(.MAX_SIDE(MAX_SIDE)) u_nbr (
        .cur_idx  (cur_idx_reg),
        .cur_row  (cur_row_reg),
        .cur_col  (cur_col_reg),
        .dir      (dir_reg),
        .rows_use (rows_use),
        .cols_use (cols_use),
        .nb_ok    (nb_ok),
        .nb_idx   (nb_idx),
        .nb_row   (nb_row),
        .nb_col   (nb_col)
    );

    gbfs_ram #(.WIDTH(KIND_W), .DEPTH(CELLS)) u_cell_ram (
        .aclk  (aclk),
        .we    (cell_we),
        .waddr (load_pos_reg[IDX_W-1:0]),
        .wdata (s_tdata[KIND_W-1:0]),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    gbfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_vis_ram (
        .aclk  (aclk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (nb_idx),
        .rdata (vis_rdata)
    );

    gbfs_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_queue_ram (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (tail_reg[IDX_W-1:0]),
        .wdata (q_wdata),
        .raddr (head_reg[IDX_W-1:0]),
        .rdata (q_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        rows_next     = rows_reg;
        cols_next     = cols_reg;
        load_pos_next = load_pos_reg;
        scan_i_next   = scan_i_reg;
        scan_row_next = scan_row_reg;
        scan_col_next = scan_col_reg;
        pipe_vld_next = 1'b0;
        pipe_idx_next = pipe_idx_reg;
        pipe_row_next = pipe_row_reg;
        pipe_col_next = pipe_col_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        cur_idx_next  = cur_idx_reg;
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        cur_step_next = cur_step_reg;
        dir_next      = dir_reg;
        nb_idx_next   = nb_idx_reg;
        nb_row_next   = nb_row_reg;
        nb_col_next   = nb_col_reg;
        found_next    = found_reg;
        steps_next    = steps_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        vis_we        = 1'b0;
        vis_waddr     = nb_idx_reg;
        vis_wdata     = 1'b1;
        q_we          = 1'b0;
        q_wdata       = {cur_step_reg, nb_col_reg, nb_row_reg, nb_idx_reg};

        if (cfg_we) begin
            case (cfg_addr)
                REG_ROWS: rows_next = cfg_wdata;
                REG_COLS: cols_next = cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            ST_LOAD: begin
                if (s_accept) begin
                    if (s_tlast) begin
                        load_pos_next = '0;
                        scan_i_next   = '0;
                        scan_row_next = '0;
                        scan_col_next = '0;
                        head_next     = '0;
                        tail_next     = '0;
                        state_next    = ST_SCAN;
                    end else if (load_pos_reg < CELL_MAX) begin
                        load_pos_next = load_pos_reg + LP_W'(1);
                    end
                end
            end
            ST_SCAN: begin
                // Issue one read per cycle; the registered code returns in the next cycle
                if (scan_i_reg < total) begin
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = scan_i_reg[IDX_W-1:0];
                    pipe_row_next = scan_row_reg;
                    pipe_col_next = scan_col_reg;
                    scan_i_next   = scan_i_reg + LP_W'(1);
                    if ((CMP_W'(scan_col_reg) + CMP_W'(1)) == CMP_W'(cols_use)) begin
                        scan_col_next = '0;
                        scan_row_next = scan_row_reg + RC_W'(1);
                    end else begin
                        scan_col_next = scan_col_reg + RC_W'(1);
                    end
                end else if (!pipe_vld_reg) begin
                    state_next = ST_DEQ;
                end
                // Clear the mark of each swept non-start cell; mark and seed start cells
                if (pipe_vld_reg) begin
                    vis_we    = 1'b1;
                    vis_waddr = pipe_idx_reg;
                    vis_wdata = (rd_kind == KIND_START);
                    if (rd_kind == KIND_START) begin
                        q_we      = 1'b1;
                        q_wdata   = {STEP_W'(0), pipe_col_reg, pipe_row_reg, pipe_idx_reg};
                        tail_next = tail_reg + LP_W'(1);
                    end
                end
            end
            ST_DEQ: begin
                if (head_reg == tail_reg) begin
                    found_next = 1'b0;
                    steps_next = '0;
                    state_next = ST_DONE;
                end else begin
                    head_next  = head_reg + LP_W'(1);
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                cur_idx_next  = q_rdata[IDX_W-1:0];
                cur_row_next  = q_rdata[IDX_W +: RC_W];
                cur_col_next  = q_rdata[IDX_W + RC_W +: RC_W];
                // Saturate the distance of the neighbors
                cur_step_next = (q_step == '1) ? q_step : q_step + STEP_W'(1);
                dir_next      = DIR_UP;
                state_next    = ST_NBR;
            end
            ST_NBR: begin
                if (nb_ok) begin
                    nb_idx_next = nb_idx;
                    nb_row_next = nb_row;
                    nb_col_next = nb_col;
                    state_next  = ST_CHK;
                end else if (dir_reg == DIR_DOWN) begin
                    state_next = ST_DEQ;
                end else begin
                    dir_next = dir_advance(dir_reg);
                end
            end
            ST_CHK: begin
                if (rd_kind == KIND_GOAL) begin
                    found_next = 1'b1;
                    steps_next = cur_step_reg;
                    state_next = ST_DONE;
                end else begin
                    if ((rd_kind == KIND_OPEN) && !vis_rdata) begin
                        vis_we    = 1'b1;
                        q_we      = 1'b1;
                        tail_next = tail_reg + LP_W'(1);
                    end
                    if (dir_reg == DIR_DOWN) begin
                        state_next = ST_DEQ;
                    end else begin
                        dir_next   = dir_advance(dir_reg);
                        state_next = ST_NBR;
                    end
                end
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{PAD_W{1'b0}}, steps_reg, found_reg};
                    state_next   = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            rows_reg     <= SIDE_RESET;
            cols_reg     <= SIDE_RESET;
            load_pos_reg <= '0;
            scan_i_reg   <= '0;
            pipe_vld_reg <= 1'b0;
            head_reg     <= '0;
            tail_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rows_reg     <= rows_next;
            cols_reg     <= cols_next;
            load_pos_reg <= load_pos_next;
            scan_i_reg   <= scan_i_next;
            pipe_vld_reg <= pipe_vld_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            m_valid_reg  <= m_valid_next;
        end
        scan_row_reg <= scan_row_next;
        scan_col_reg <= scan_col_next;
        pipe_idx_reg <= pipe_idx_next;
        pipe_row_reg <= pipe_row_next;
        pipe_col_reg <= pipe_col_next;
        cur_idx_reg  <= cur_idx_next;
        cur_row_reg  <= cur_row_next;
        cur_col_reg  <= cur_col_next;
        cur_step_reg <= cur_step_next;
        dir_reg      <= dir_next;
        nb_idx_reg   <= nb_idx_next;
        nb_row_reg   <= nb_row_next;
        nb_col_reg   <= nb_col_next;
        found_reg    <= found_next;
        steps_reg    <= steps_next;
        m_data_reg   <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/gbfs_chk.sv =====
// Port-level checker of the grid search block and its bind.
module gbfs_chk (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             s_tlast,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [gbfs_pkg::M_TDATA_W-1:0]   m_tdata
);
    import gbfs_pkg::*;

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // No goal means a zero distance
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[STEP_W:1] == '0)
        else $error("step_count nonzero without a goal");

    // A reached goal is at least one step away
    a_hit_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[STEP_W:1] != '0)
        else $error("goal found at zero steps");

    // The last cell starts a search, so input stalls next cycle
    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input ready right after last cell");

    // Reset drops any pending result
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind grid_bfs_shortest_path gbfs_chk u_gbfs_chk (.*);

// ===== bench/tb_top.sv =====
// Self-checking bench for the grid shortest-path search block.
`timescale 1ns / 100ps

module tb_top;
    import gbfs_pkg::*;

    localparam int MAX_SIDE   = 32;
    localparam int CELL_SLOTS = MAX_SIDE * MAX_SIDE;
    localparam int STEP_CAP   = (1 << STEP_W) - 1;
    localparam int HOLD_SPAN  = 3000;

    typedef struct {
        cell_kind_t kind;
        bit         last;
    } cell_word_t;

    typedef struct {
        bit                found;
        logic [STEP_W-1:0] steps;
    } path_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = REG_ROWS;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;     // [1:0] cell_kind, [7:2] zero
    logic                  s_tlast   = 1'b0;   // last_cell
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;            // [0] goal_found, [11:1] step_count

    grid_bfs_shortest_path #(
        .MAX_SIDE(MAX_SIDE)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Search predictor: own copy of the grid store, sizes and load pointer
    // ------------------------------------------------------------------
    cell_kind_t       grid_mem [CELL_SLOTS];
    logic [CFG_W-1:0] rows_reg = SIDE_RESET;
    logic [CFG_W-1:0] cols_reg = SIDE_RESET;
    int unsigned      load_ptr = 0;
    bit               seen_mark [CELL_SLOTS];
    int unsigned      frontier_idx [CELL_SLOTS];
    int unsigned      frontier_dist [CELL_SLOTS];
    int unsigned      frontier_tail;

    path_result_t     pending_paths[$];   // predicted results, oldest first
    cell_word_t       cell_words[$];      // words waiting for the sender

    int unsigned      words_queued  = 0;
    int unsigned      words_taken   = 0;
    int unsigned      results_seen  = 0;
    int unsigned      error_count   = 0;
    bit               word_taken    = 1'b0;

    // A size of zero counts as one, anything past the grid limit as the limit.
    function automatic int unsigned side_used(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_SIDE)
            return MAX_SIDE;
        return 32'(v);
    endfunction

    // Look at one neighbor: report a goal, enqueue an unvisited open cell.
    function automatic bit probe_cell(input int unsigned idx, input int unsigned hops);
        if (grid_mem[idx] == KIND_GOAL)
            return 1'b1;
        if (grid_mem[idx] == KIND_OPEN && !seen_mark[idx]) begin
            seen_mark[idx]               = 1'b1;
            frontier_idx[frontier_tail]  = idx;
            frontier_dist[frontier_tail] = hops;
            frontier_tail++;
        end
        return 1'b0;
    endfunction

    // Multi-source search from every start; neighbors in the order up, right, left, down.
    function automatic path_result_t search_grid();
        int unsigned  rows, cols, head, idx, hops, r, c, i;
        bit           hit;
        path_result_t res;
        rows          = side_used(rows_reg);
        cols          = side_used(cols_reg);
        res.found     = 1'b0;
        res.steps     = '0;
        head          = 0;
        frontier_tail = 0;
        for (i = 0; i < CELL_SLOTS; i++)
            seen_mark[i] = 1'b0;
        for (i = 0; i < rows * cols; i++) begin
            if (grid_mem[i] == KIND_START) begin
                seen_mark[i]                 = 1'b1;
                frontier_idx[frontier_tail]  = i;
                frontier_dist[frontier_tail] = 0;
                frontier_tail++;
            end
        end
        while (head < frontier_tail) begin
            idx  = frontier_idx[head];
            hops = frontier_dist[head] + 1;
            r    = idx / cols;
            c    = idx % cols;
            head++;
            hit  = 1'b0;
            if (r > 0)
                hit = probe_cell(idx - cols, hops);
            if (!hit && c + 1 < cols)
                hit = probe_cell(idx + 1, hops);
            if (!hit && c > 0)
                hit = probe_cell(idx - 1, hops);
            if (!hit && r + 1 < rows)
                hit = probe_cell(idx + cols, hops);
            if (hit) begin
                res.found = 1'b1;
                res.steps = (hops > STEP_CAP) ? STEP_CAP[STEP_W-1:0] : hops[STEP_W-1:0];
                return res;
            end
        end
        return res;
    endfunction

    // Store one accepted cell; the last one runs the search and rewinds the load pointer.
    function automatic void accept_cell(input cell_kind_t kind, input bit last);
        int unsigned total;
        total = side_used(rows_reg) * side_used(cols_reg);
        if (load_ptr < total)
            grid_mem[load_ptr] = kind;
        if (load_ptr < CELL_SLOTS)
            load_ptr++;
        if (last) begin
            pending_paths.push_back(search_grid());
            load_ptr = 0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sample both channels and the register port at the rising edge
    // ------------------------------------------------------------------
    path_result_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg = SIDE_RESET;
            cols_reg = SIDE_RESET;
            load_ptr = 0;
            pending_paths.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_ROWS: rows_reg = cfg_wdata;
                    REG_COLS: cols_reg = cfg_wdata;
                    default: ;
                endcase
            end
            // Check results before predicting, so a stray word never meets a fresh guess.
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (pending_paths.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, m_tdata);
                    error_count++;
                end else begin
                    want = pending_paths.pop_front();
                    if (m_tdata[0] !== want.found) begin
                        $display("%0t: goal_found mismatch, expected %0d, actual %0d",
                                 $time, want.found, m_tdata[0]);
                        error_count++;
                    end
                    if (m_tdata[STEP_W:1] !== want.steps) begin
                        $display("%0t: step_count mismatch, expected %0d, actual %0d",
                                 $time, want.steps, m_tdata[STEP_W:1]);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                word_taken = 1'b1;
                words_taken++;
                accept_cell(cell_kind_t'(s_tdata[KIND_W-1:0]), s_tlast);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender: bursts of random length with random gaps, fed from cell_words
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    cell_word_t  next_word;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || word_taken) begin
            word_taken = 1'b0;
            if (gap_left != 0) begin
                // idle this cycle
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (cell_words.size() != 0) begin
                next_word = cell_words.pop_front();
                s_tdata  <= {{(S_TDATA_W-KIND_W){1'b0}}, next_word.kind};
                s_tlast  <= next_word.last;
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    // close the burst; a quarter of them run on with no gap
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: rotating ready pattern, reshuffled every so often, plus one
    // long hold-off while the sender still has words so the input backs up
    // ------------------------------------------------------------------
    int unsigned hold_left  = 0;
    bit          hold_done  = 1'b0;
    int unsigned mode_left  = 0;
    int unsigned ready_mode = 0;
    logic [15:0] ready_pat  = '1;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && results_seen >= 10 && cell_words.size() != 0) begin
            hold_done = 1'b1;
            hold_left = HOLD_SPAN;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode_left  = 150;
                ready_mode = $urandom_range(0, 2);
                ready_pat  = 16'($urandom);
            end
            mode_left--;
            ready_pat = {ready_pat[14:0], ready_pat[15]};
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ready_pat[0];
                default: m_tready <= ready_pat[0] & ready_pat[7];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_cells(input cell_kind_t cells[$]);
        cell_word_t w;
        foreach (cells[k]) begin
            w.kind = cells[k];
            w.last = (k == cells.size() - 1);
            cell_words.push_back(w);
            words_queued++;
        end
    endtask

    // Drive one register write on the falling edge; return just after a rising edge.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    // Wait until every word is taken and every result is back, then let loading settle.
    task automatic wait_idle();
        while (words_taken != words_queued || pending_paths.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_size(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
        write_reg(REG_ROWS, rows);
        write_reg(REG_COLS, cols);
    endtask

    // Mostly small sides, some medium, a few zero or oversize.
    function automatic logic [CFG_W-1:0] pick_side();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 4)
            return CFG_W'($urandom_range(MAX_SIDE + 1, (1 << CFG_W) - 1));
        if (sel < 8)
            return '0;
        if (sel < 25)
            return CFG_W'($urandom_range(9, MAX_SIDE));
        return CFG_W'($urandom_range(1, 8));
    endfunction

    // Random maze: well-formed most of the time, sometimes cut short, overlong or noise.
    task automatic queue_random_grid(input int unsigned rows, input int unsigned cols);
        cell_kind_t  layout[$];
        int unsigned total, mode, wall_pct, n_starts, n_goals, len, k;
        total    = rows * cols;
        mode     = $urandom_range(0, 99);
        wall_pct = $urandom_range(0, 45);
        for (k = 0; k < total; k++) begin
            if (mode < 10)
                layout.push_back(cell_kind_t'($urandom_range(0, 3)));
            else
                layout.push_back(($urandom_range(0, 99) < wall_pct) ? KIND_WALL : KIND_OPEN);
        end
        n_starts = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 3);
        n_goals  = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 3);
        repeat (n_starts) layout[$urandom_range(0, total - 1)] = KIND_START;
        repeat (n_goals)  layout[$urandom_range(0, total - 1)] = KIND_GOAL;
        if (mode >= 10 && mode < 18 && total > 1) begin
            // last cell early: the tail keeps what the store held before
            len = $urandom_range(1, total - 1);
            while (layout.size() > len)
                void'(layout.pop_back());
        end else if (mode >= 18 && mode < 26) begin
            // cells past the grid are dropped
            repeat ($urandom_range(1, 5)) layout.push_back(cell_kind_t'($urandom_range(0, 3)));
        end
        queue_cells(layout);
    endtask

    initial begin : stimulus
        cell_kind_t       layout[$];
        int unsigned      r, c;
        logic [CFG_W-1:0] rows_raw, cols_raw;

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Full 32x32 serpentine at the reset sizes. It also writes every cell,
        // so no later search can read a cell that was never loaded.
        for (r = 0; r < MAX_SIDE; r++) begin
            for (c = 0; c < MAX_SIDE; c++) begin
                if (r == 0 && c == 0)
                    layout.push_back(KIND_START);
                else if (r == MAX_SIDE - 2 && c == 0)
                    layout.push_back(KIND_GOAL);
                else if (r % 2 == 0)
                    layout.push_back(KIND_OPEN);
                else if ((r % 4 == 1 && c == MAX_SIDE - 1) || (r % 4 == 3 && c == 0))
                    layout.push_back(KIND_OPEN);
                else
                    layout.push_back(KIND_WALL);
            end
        end
        queue_cells(layout);
        wait_idle();

        // Zero sizes: a lone start with nowhere to go
        set_size('0, '0);
        queue_cells('{KIND_START});
        wait_idle();
        // goal right next to the start
        set_size(6'd1, 6'd2);
        queue_cells('{KIND_START, KIND_GOAL});
        wait_idle();
        // no start at all
        queue_cells('{KIND_GOAL, KIND_OPEN});
        wait_idle();
        // cells past the grid are dropped
        queue_cells('{KIND_GOAL, KIND_START, KIND_WALL, KIND_WALL});
        wait_idle();
        // goal behind a wall
        set_size(6'd1, 6'd3);
        queue_cells('{KIND_GOAL, KIND_WALL, KIND_START});
        wait_idle();
        // detour around a wall, two steps
        set_size(6'd2, 6'd2);
        queue_cells('{KIND_WALL, KIND_GOAL, KIND_START, KIND_OPEN});
        wait_idle();
        // early last cell: the rest of the grid stays from before
        queue_cells('{KIND_GOAL});
        wait_idle();
        // a start next to a start is never entered
        queue_cells('{KIND_START, KIND_START, KIND_OPEN, KIND_GOAL});
        wait_idle();
        // oversize rows, zero cols: one tall column
        set_size('1, '0);
        layout.delete();
        layout.push_back(KIND_START);
        repeat (MAX_SIDE - 2) layout.push_back(KIND_OPEN);
        layout.push_back(KIND_GOAL);
        queue_cells(layout);
        wait_idle();
        // zero rows, oversize cols: one wide row, goal first
        set_size('0, '1);
        layout.delete();
        layout.push_back(KIND_GOAL);
        repeat (MAX_SIDE - 2) layout.push_back(KIND_OPEN);
        layout.push_back(KIND_START);
        queue_cells(layout);
        wait_idle();

        // Random phases: new sizes while idle, then a few grids back to back
        while (words_queued < 2000) begin
            if ($urandom_range(0, 4) != 0) begin
                rows_raw = pick_side();
                cols_raw = pick_side();
                set_size(rows_raw, cols_raw);
            end
            repeat ($urandom_range(1, 5)) begin
                queue_random_grid(side_used(rows_reg), side_used(cols_reg));
            end
            wait_idle();
        end

        // drain, then watch for stray words
        repeat (200) @(posedge aclk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: several times the slowest legal run
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
